// ===== rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Shared constants, token type and keyword tables for the source token scanner.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int POS_BITS    = 16;
	localparam int OUT_W       = 16;
	localparam int KW_MAX_LEN  = 9;
	localparam int KW_IDX_BITS = $clog2(KW_MAX_LEN);
	localparam int NUM_KW      = 16;
	localparam int NUM_OP      = 4;
	localparam int NUM_SYM     = 8;
	localparam int TQ_DEPTH    = 4;
	localparam int TQ_PTR_BITS = $clog2(TQ_DEPTH);
	localparam int TQ_CNT_BITS = $clog2(TQ_DEPTH + 1);

	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic [5:0]          kind_t;

	localparam kind_t KIND_INT   = 6'd0;
	localparam kind_t KIND_FLOAT = 6'd1;
	localparam kind_t KIND_IDENT = 6'd2;
	localparam kind_t KIND_KW0   = 6'd3;
	localparam kind_t KIND_OP0   = 6'd19;
	localparam kind_t KIND_SYM0  = 6'd27;
	localparam kind_t KIND_ERR   = 6'd35;

	localparam logic [7:0] CH_DOT    = ".";
	localparam logic [7:0] CH_EQ     = "=";
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = " ";
	localparam logic [7:0] CH_USCORE = "_";

	// keyword text, right-justified: last char in the low byte
	localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
		"interface", "struct", "enum", "fn", "let", "match", "if", "while",
		"for", "void", "int", "float", "str", "bool", "true", "false"
	};
	localparam int KW_LEN [NUM_KW] = '{9, 6, 4, 2, 3, 5, 2, 5, 3, 4, 3, 5, 3, 4, 4, 5};

	localparam logic [7:0] OP_CHARS  [NUM_OP]  = '{"=", "!", "<", ">"};
	localparam logic [7:0] SYM_CHARS [NUM_SYM] = '{"{", "}", "(", ")", ";", ":", ",", "?"};

	typedef struct packed {
		kind_t            token_kind;
		logic [OUT_W-1:0] start_offset;
		logic [OUT_W-1:0] token_length;
		logic [OUT_W-1:0] line_number;
		logic             run_last;
		logic             source_done;
	} token_t;

	function automatic pos_t sat_inc(pos_t v);
		return (v == '1) ? v : v + pos_t'(1);
	endfunction

	function automatic logic [OUT_W-1:0] to_out(pos_t v);
		logic [31:0] w;
		w = 32'(v);
		return w[OUT_W-1:0];
	endfunction

	// char c matches keyword k at position pos
	function automatic logic kw_hit(int k, logic [KW_IDX_BITS-1:0] pos, logic [7:0] c);
		int   shamt;
		logic hit;
		hit = 1'b0;
		if (int'(pos) < KW_LEN[k]) begin
			shamt = 8 * (KW_LEN[k] - 1 - int'(pos));
			hit   = (KW_TEXT[k][shamt +: 8] == c);
		end
		return hit;
	endfunction

endpackage

// ===== rtl/scs_lexer.sv =====
// ----------------------------------------------------------------------------
// scs_lexer
// Scan state and per-byte token logic; up to two tokens per byte.
// ----------------------------------------------------------------------------
module scs_lexer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [7:0]                in_byte,
	input  logic                      in_final,
	output scs_pkg::token_t [1:0]     toks,
	output logic [1:0]                tok_cnt
);

	typedef enum logic [2:0] {PH_IDLE, PH_INT, PH_FRAC, PH_WORD, PH_OPER} phase_t;

	phase_t                         phase_q, ph_m;
	logic [1:0]                     op_q, op_m;
	logic [scs_pkg::NUM_KW-1:0]     kwm_q, kwm_m;
	scs_pkg::pos_t                  begin_q, begin_m;
	scs_pkg::pos_t                  len_q, len_m;
	scs_pkg::pos_t                  pos_q;
	scs_pkg::pos_t                  line_q, line_m;

	logic                           dig_hit, ltr_hit, is_blank, is_nl;
	logic                           op_hit, sym_hit;
	logic [1:0]                     op_idx;
	logic [2:0]                     sym_idx;

	logic                           a_vld, b_vld, c_vld, do_start;
	scs_pkg::kind_t                 a_kind, b_kind, c_kind;
	scs_pkg::pos_t                  a_len;
	scs_pkg::token_t                tok_a, tok_b, tok_c, tok_sec;
	logic                           sec_vld;

	function automatic scs_pkg::kind_t flush_kind(phase_t ph, logic [1:0] op,
			logic [scs_pkg::NUM_KW-1:0] kwm, scs_pkg::pos_t len);
		scs_pkg::kind_t k;
		k = scs_pkg::KIND_ERR;
		case (ph)
			PH_INT:  k = scs_pkg::KIND_INT;
			PH_FRAC: k = scs_pkg::KIND_FLOAT;
			PH_OPER: k = scs_pkg::KIND_OP0 + scs_pkg::kind_t'({op, 1'b0});
			PH_WORD: begin
				k = scs_pkg::KIND_IDENT;
				if (len <= scs_pkg::pos_t'(scs_pkg::KW_MAX_LEN)) begin
					for (int i = scs_pkg::NUM_KW - 1; i >= 0; i--) begin
						if (kwm[i] && len == scs_pkg::pos_t'(scs_pkg::KW_LEN[i]))
							k = scs_pkg::KIND_KW0 + scs_pkg::kind_t'(i);
					end
				end
			end
			default: k = scs_pkg::KIND_ERR;
		endcase
		return k;
	endfunction

	always_comb begin
		dig_hit  = (in_byte >= "0") && (in_byte <= "9");
		ltr_hit  = ((in_byte >= "a") && (in_byte <= "z")) ||
			((in_byte >= "A") && (in_byte <= "Z")) || (in_byte == scs_pkg::CH_USCORE);
		is_blank = (in_byte == scs_pkg::CH_SPACE) || (in_byte == scs_pkg::CH_TAB) ||
			(in_byte == scs_pkg::CH_CR);
		is_nl    = (in_byte == scs_pkg::CH_NL);
		op_hit   = 1'b0;
		op_idx   = '0;
		for (int i = 0; i < scs_pkg::NUM_OP; i++) begin
			if (in_byte == scs_pkg::OP_CHARS[i]) begin
				op_hit = 1'b1;
				op_idx = 2'(i);
			end
		end
		sym_hit = 1'b0;
		sym_idx = '0;
		for (int i = 0; i < scs_pkg::NUM_SYM; i++) begin
			if (in_byte == scs_pkg::SYM_CHARS[i]) begin
				sym_hit = 1'b1;
				sym_idx = 3'(i);
			end
		end
	end

	always_comb begin
		ph_m     = phase_q;
		op_m     = op_q;
		kwm_m    = kwm_q;
		begin_m  = begin_q;
		len_m    = len_q;
		line_m   = line_q;
		a_vld    = 1'b0;
		a_kind   = flush_kind(phase_q, op_q, kwm_q, len_q);
		a_len    = len_q;
		b_vld    = 1'b0;
		b_kind   = scs_pkg::KIND_ERR;
		do_start = 1'b0;
		unique case (phase_q)
			PH_INT: begin
				if (dig_hit) begin
					len_m = scs_pkg::sat_inc(len_q);
				end else if (in_byte == scs_pkg::CH_DOT) begin
					len_m = scs_pkg::sat_inc(len_q);
					ph_m  = PH_FRAC;
				end else begin
					a_vld    = 1'b1;
					do_start = 1'b1;
				end
			end
			PH_FRAC: begin
				if (dig_hit) begin
					len_m = scs_pkg::sat_inc(len_q);
				end else begin
					a_vld    = 1'b1;
					do_start = 1'b1;
				end
			end
			PH_WORD: begin
				if (ltr_hit || dig_hit) begin
					for (int k = 0; k < scs_pkg::NUM_KW; k++)
						kwm_m[k] = kwm_q[k] && (len_q < scs_pkg::pos_t'(scs_pkg::KW_MAX_LEN)) &&
							scs_pkg::kw_hit(k, len_q[scs_pkg::KW_IDX_BITS-1:0], in_byte);
					len_m = scs_pkg::sat_inc(len_q);
				end else begin
					a_vld    = 1'b1;
					do_start = 1'b1;
				end
			end
			PH_OPER: begin
				if (in_byte == scs_pkg::CH_EQ) begin
					a_vld  = 1'b1;
					a_kind = scs_pkg::KIND_OP0 + scs_pkg::kind_t'({op_q, 1'b1});
					a_len  = scs_pkg::sat_inc(len_q);
					ph_m   = PH_IDLE;
				end else begin
					a_vld    = 1'b1;
					do_start = 1'b1;
				end
			end
			PH_IDLE: do_start = 1'b1;
			default: do_start = 1'b1;
		endcase
		if (do_start) begin
			ph_m = PH_IDLE;
			if (is_nl) begin
				line_m = scs_pkg::sat_inc(line_q);
			end else if (!is_blank) begin
				begin_m = pos_q;
				len_m   = scs_pkg::pos_t'(1);
				if (dig_hit) begin
					ph_m = PH_INT;
				end else if (ltr_hit) begin
					ph_m = PH_WORD;
					for (int k = 0; k < scs_pkg::NUM_KW; k++)
						kwm_m[k] = scs_pkg::kw_hit(k, '0, in_byte);
				end else if (op_hit) begin
					ph_m = PH_OPER;
					op_m = op_idx;
				end else begin
					b_vld  = 1'b1;
					b_kind = sym_hit ? scs_pkg::KIND_SYM0 + scs_pkg::kind_t'(sym_idx)
						: scs_pkg::KIND_ERR;
				end
			end
		end
		c_vld  = in_final && (ph_m != PH_IDLE);
		c_kind = flush_kind(ph_m, op_m, kwm_m, len_m);
	end

	always_comb begin
		tok_a = '{token_kind: a_kind, start_offset: scs_pkg::to_out(begin_q),
			token_length: scs_pkg::to_out(a_len), line_number: scs_pkg::to_out(line_q),
			run_last: 1'b0, source_done: 1'b0};
		tok_b = '{token_kind: b_kind, start_offset: scs_pkg::to_out(pos_q),
			token_length: scs_pkg::OUT_W'(1), line_number: scs_pkg::to_out(line_q),
			run_last: 1'b0, source_done: 1'b0};
		tok_c = '{token_kind: c_kind, start_offset: scs_pkg::to_out(begin_m),
			token_length: scs_pkg::to_out(len_m), line_number: scs_pkg::to_out(line_q),
			run_last: 1'b0, source_done: 1'b0};
		tok_sec = b_vld ? tok_b : tok_c;
		sec_vld = b_vld || c_vld;
		if (a_vld) begin
			toks[0] = tok_a;
			toks[1] = tok_sec;
			tok_cnt = sec_vld ? 2'd2 : 2'd1;
		end else begin
			toks[0] = tok_sec;
			toks[1] = tok_sec;
			tok_cnt = sec_vld ? 2'd1 : 2'd0;
		end
		toks[0].run_last    = (tok_cnt == 2'd1);
		toks[0].source_done = in_final && (tok_cnt == 2'd1);
		toks[1].run_last    = 1'b1;
		toks[1].source_done = in_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q    <= '0;
			begin_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			line_q  <= scs_pkg::pos_t'(1);
		end else if (fire) begin
			op_q <= op_m;
			if (in_final) begin
				phase_q <= PH_IDLE;
				begin_q <= '0;
				len_q   <= '0;
				pos_q   <= '0;
				line_q  <= scs_pkg::pos_t'(1);
			end else begin
				phase_q <= ph_m;
				begin_q <= begin_m;
				len_q   <= len_m;
				pos_q   <= scs_pkg::sat_inc(pos_q);
				line_q  <= line_m;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			kwm_q <= kwm_m;
	end

endmodule

// ===== rtl/scs_tok_fifo.sv =====
// ----------------------------------------------------------------------------
// scs_tok_fifo
// Small token queue: takes up to two tokens per cycle, gives one per beat.
// ----------------------------------------------------------------------------
module scs_tok_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [1:0]             push_cnt,
	input  scs_pkg::token_t [1:0]  push_toks,
	input  logic                   pop,
	output scs_pkg::token_t        head,
	output logic                   head_vld,
	output logic                   space_ok
);

	scs_pkg::token_t                     mem_q [scs_pkg::TQ_DEPTH];
	logic [scs_pkg::TQ_PTR_BITS-1:0]     wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [scs_pkg::TQ_CNT_BITS-1:0]     cnt_q, add_n;

	assign wr_ptr_1 = wr_ptr_q + scs_pkg::TQ_PTR_BITS'(1);
	assign add_n    = push ? scs_pkg::TQ_CNT_BITS'(push_cnt) : '0;
	assign head     = mem_q[rd_ptr_q];
	assign head_vld = (cnt_q != '0);
	assign space_ok = (cnt_q <= scs_pkg::TQ_CNT_BITS'(scs_pkg::TQ_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + scs_pkg::TQ_PTR_BITS'(add_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + scs_pkg::TQ_PTR_BITS'(1);
			cnt_q <= cnt_q + add_n - (pop ? scs_pkg::TQ_CNT_BITS'(1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (push && push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push_toks[0];
		if (push && push_cnt == 2'd2)
			mem_q[wr_ptr_1] <= push_toks[1];
	end

endmodule

// ===== rtl/source_token_scanner.sv =====
// ----------------------------------------------------------------------------
// source_token_scanner
// Streaming lexer: one source byte per beat in, one token per beat out.
//
//  channel  | dir | tdata                                   | tlast      | tuser
//  s_axis   | in  | [7:0] text_byte                         | final_byte | -
//  m_axis   | out | [5:0] kind [21:6] offset [37:22] length | run_last   | source_done
//           |     | [53:38] line [55:54] zero               |            |
//
// One byte per cycle when not stalled. A byte that yields tokens waits in the
// input register while the 4-entry token queue holds three or more, so two-token
// bytes back to back are held there while the queue drains. A byte is registered
// first, then its tokens in the token queue. Reset clears scan state; line count
// starts at 1. Output stalls back up through the token queue into the input register.
// ----------------------------------------------------------------------------
module source_token_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // kind, start_offset, token_length, line_number, pad
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // [0] source_done
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   final_s1;
	logic                   fire, space_ok, pop;
	logic [1:0]             tok_cnt;
	scs_pkg::token_t [1:0]  toks;
	scs_pkg::token_t        head;

	assign fire          = valid_s1 && (space_ok || tok_cnt == 2'd0);
	assign s_axis_tready = !valid_s1 || fire;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			final_s1 <= s_axis_tlast;
		end
	end

	scs_lexer u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.in_byte  (byte_s1),
		.in_final (final_s1),
		.toks     (toks),
		.tok_cnt  (tok_cnt)
	);

	scs_tok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_cnt  (tok_cnt),
		.push_toks (toks),
		.pop       (pop),
		.head      (head),
		.head_vld  (m_axis_tvalid),
		.space_ok  (space_ok)
	);

	assign m_axis_tdata = {2'b00, head.line_number, head.token_length,
		head.start_offset, head.token_kind};
	assign m_axis_tlast = head.run_last;
	assign m_axis_tuser = head.source_done;

endmodule

// ===== tb/source_token_scanner_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_scanner_test
// Streams source text into the scanner with random source boundaries, gaps
// and output stalls, predicts every token in the testbench and compares each
// output beat field by field against the oldest predicted token.
// ----------------------------------------------------------------------------
module source_token_scanner_test;

	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD    = 300;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_INT, SCAN_FRAC, SCAN_WORD, SCAN_OPER
	} scan_state_t;

	typedef struct packed {
		logic [7:0] text;
		logic       fin;
	} text_beat_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	source_token_scanner dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] text_byte
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [5:0] kind [21:6] offset [37:22] length [53:38] line
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)    // [0] source_done
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	string keyword_names [scs_pkg::NUM_KW] = '{
		"interface", "struct", "enum", "fn", "let", "match", "if", "while",
		"for", "void", "int", "float", "str", "bool", "true", "false"
	};

	text_beat_t       pending_bytes [$];
	scs_pkg::token_t  expected_tokens [$];
	int               error_count   = 0;
	int               send_idle_max = 0;
	int               recv_idle_max = 0;
	int               long_hold_len = 0;

	// ---------------- token predictor ----------------
	scan_state_t      scan_state = SCAN_IDLE;
	logic [1:0]       op_sel     = '0;
	logic [7:0]       word_buf [scs_pkg::KW_MAX_LEN];
	scs_pkg::pos_t    tok_begin  = '0;
	scs_pkg::pos_t    tok_len    = '0;
	scs_pkg::pos_t    byte_pos   = '0;
	scs_pkg::pos_t    line_no    = scs_pkg::pos_t'(1);
	scs_pkg::token_t  step_out [2];
	int               step_count;

	function automatic scs_pkg::pos_t bump(scs_pkg::pos_t v);
		return (v == '1) ? v : v + scs_pkg::pos_t'(1);
	endfunction

	function automatic bit is_num_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_word_start(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == scs_pkg::CH_USCORE;
	endfunction

	function automatic void emit_token(scs_pkg::kind_t kind, scs_pkg::pos_t from,
			scs_pkg::pos_t len);
		scs_pkg::token_t t;
		if (step_count < 2) begin
			t.token_kind   = kind;
			t.start_offset = from;
			t.token_length = len;
			t.line_number  = line_no;
			t.run_last     = 1'b0;
			t.source_done  = 1'b0;
			step_out[step_count] = t;
			step_count++;
		end
	endfunction

	function automatic scs_pkg::kind_t classify_word();
		bit same;
		if (tok_len > scs_pkg::pos_t'(scs_pkg::KW_MAX_LEN))
			return scs_pkg::KIND_IDENT;
		for (int k = 0; k < scs_pkg::NUM_KW; k++) begin
			if (keyword_names[k].len() == int'(tok_len)) begin
				same = 1'b1;
				for (int i = 0; i < keyword_names[k].len(); i++)
					if (word_buf[i] != keyword_names[k][i])
						same = 1'b0;
				if (same)
					return scs_pkg::kind_t'(scs_pkg::KIND_KW0 + k);
			end
		end
		return scs_pkg::KIND_IDENT;
	endfunction

	function automatic void flush_token();
		case (scan_state)
			SCAN_INT:  emit_token(scs_pkg::KIND_INT, tok_begin, tok_len);
			SCAN_FRAC: emit_token(scs_pkg::KIND_FLOAT, tok_begin, tok_len);
			SCAN_WORD: emit_token(classify_word(), tok_begin, tok_len);
			SCAN_OPER: emit_token(scs_pkg::kind_t'(scs_pkg::KIND_OP0 + 2 * op_sel),
				tok_begin, tok_len);
			default: ;
		endcase
		scan_state = SCAN_IDLE;
	endfunction

	function automatic void open_token(logic [7:0] c);
		bit found;
		found = 1'b0;
		if (c == scs_pkg::CH_NL) begin
			line_no = bump(line_no);
		end else if (c != scs_pkg::CH_SPACE && c != scs_pkg::CH_TAB &&
				c != scs_pkg::CH_CR) begin
			tok_begin = byte_pos;
			tok_len   = scs_pkg::pos_t'(1);
			if (is_num_char(c)) begin
				scan_state = SCAN_INT;
			end else if (is_word_start(c)) begin
				word_buf[0] = c;
				scan_state  = SCAN_WORD;
			end else begin
				for (int k = 0; k < scs_pkg::NUM_OP; k++)
					if (!found && scs_pkg::OP_CHARS[k] == c) begin
						op_sel     = 2'(k);
						scan_state = SCAN_OPER;
						found      = 1'b1;
					end
				for (int k = 0; k < scs_pkg::NUM_SYM; k++)
					if (!found && scs_pkg::SYM_CHARS[k] == c) begin
						emit_token(scs_pkg::kind_t'(scs_pkg::KIND_SYM0 + k), tok_begin,
							scs_pkg::pos_t'(1));
						found = 1'b1;
					end
				if (!found)
					emit_token(scs_pkg::KIND_ERR, tok_begin, scs_pkg::pos_t'(1));
			end
		end
	endfunction

	function automatic void predict_tokens(logic [7:0] c, logic fin);
		step_count = 0;
		case (scan_state)
			SCAN_INT: begin
				if (is_num_char(c)) begin
					tok_len = bump(tok_len);
				end else if (c == scs_pkg::CH_DOT) begin
					tok_len    = bump(tok_len);
					scan_state = SCAN_FRAC;
				end else begin
					flush_token();
					open_token(c);
				end
			end
			SCAN_FRAC: begin
				if (is_num_char(c)) begin
					tok_len = bump(tok_len);
				end else begin
					flush_token();
					open_token(c);
				end
			end
			SCAN_WORD: begin
				if (is_word_start(c) || is_num_char(c)) begin
					if (tok_len < scs_pkg::pos_t'(scs_pkg::KW_MAX_LEN))
						word_buf[tok_len[scs_pkg::KW_IDX_BITS-1:0]] = c;
					tok_len = bump(tok_len);
				end else begin
					flush_token();
					open_token(c);
				end
			end
			SCAN_OPER: begin
				if (c == scs_pkg::CH_EQ) begin
					tok_len = bump(tok_len);
					emit_token(scs_pkg::kind_t'(scs_pkg::KIND_OP0 + 2 * op_sel + 1),
						tok_begin, tok_len);
					scan_state = SCAN_IDLE;
				end else begin
					flush_token();
					open_token(c);
				end
			end
			default: begin
				scan_state = SCAN_IDLE;
				open_token(c);
			end
		endcase
		byte_pos = bump(byte_pos);
		if (fin) begin
			flush_token();
			if (step_count > 0)
				step_out[step_count-1].source_done = 1'b1;
			byte_pos  = '0;
			line_no   = scs_pkg::pos_t'(1);
			tok_len   = '0;
			tok_begin = '0;
		end
		if (step_count > 0)
			step_out[step_count-1].run_last = 1'b1;
		for (int i = 0; i < step_count; i++)
			expected_tokens.push_back(step_out[i]);
	endfunction

	// ---------------- driver ----------------
	int send_wait = 0;

	always @(posedge clk or negedge arst_n) begin
		text_beat_t next_beat;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			s_axis_tlast  <= 1'b0;
			send_wait = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_tokens(s_axis_tdata, s_axis_tlast);
				send_wait = $urandom_range(0, send_idle_max);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					next_beat = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= next_beat.text;
					s_axis_tlast  <= next_beat.fin;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	int recv_wait = 0;
	int hold_left = 0;

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch: %s got %0d expected %0d", field, got, want);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		scs_pkg::token_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch("unexpected token, kind", longint'(m_axis_tdata[5:0]),
						longint'(-1));
				end else begin
					want = expected_tokens.pop_front();
					if (m_axis_tdata[5:0] != want.token_kind)
						report_mismatch("token_kind", longint'(m_axis_tdata[5:0]),
							longint'(want.token_kind));
					if (m_axis_tdata[21:6] != want.start_offset)
						report_mismatch("start_offset", longint'(m_axis_tdata[21:6]),
							longint'(want.start_offset));
					if (m_axis_tdata[37:22] != want.token_length)
						report_mismatch("token_length", longint'(m_axis_tdata[37:22]),
							longint'(want.token_length));
					if (m_axis_tdata[53:38] != want.line_number)
						report_mismatch("line_number", longint'(m_axis_tdata[53:38]),
							longint'(want.line_number));
					if (m_axis_tdata[55:54] != 2'b00)
						report_mismatch("pad", longint'(m_axis_tdata[55:54]), longint'(0));
					if (m_axis_tlast != want.run_last)
						report_mismatch("run_last", longint'(m_axis_tlast),
							longint'(want.run_last));
					if (m_axis_tuser != want.source_done)
						report_mismatch("source_done", longint'(m_axis_tuser),
							longint'(want.source_done));
				end
				recv_wait = $urandom_range(0, recv_idle_max);
			end
			if (long_hold_len > 0) begin
				hold_left     = long_hold_len;
				long_hold_len = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ---------------- watchdog ----------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else if (pending_bytes.size() > 0 || s_axis_tvalid || expected_tokens.size() > 0)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------
	int bytes_queued = 0;

	task automatic add_byte(logic [7:0] c);
		text_beat_t b;
		b.text = c;
		b.fin  = 1'b0;
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic close_source();
		text_beat_t b;
		b = pending_bytes.pop_back();
		b.fin = 1'b1;
		pending_bytes.push_back(b);
	endtask

	function automatic logic [7:0] word_char(bit first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		if (r == 52)
			return scs_pkg::CH_USCORE;
		return 8'("0" + r - 53);
	endfunction

	task automatic add_digits(int n);
		for (int i = 0; i < n; i++)
			add_byte(8'("0" + $urandom_range(0, 9)));
	endtask

	task automatic add_blank();
		case ($urandom_range(0, 3))
			0: add_byte(scs_pkg::CH_SPACE);
			1: add_byte(scs_pkg::CH_TAB);
			2: add_byte(scs_pkg::CH_CR);
			default: add_byte(scs_pkg::CH_NL);
		endcase
	endtask

	task automatic add_lexeme();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			add_digits($urandom_range(1, 4));
		end else if (pick < 22) begin
			add_digits($urandom_range(1, 3));
			add_byte(scs_pkg::CH_DOT);
			add_digits($urandom_range(0, 3));
		end else if (pick < 40) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
			add_byte(word_char(1'b1));
			for (int i = 1; i < n; i++)
				add_byte(word_char(1'b0));
		end else if (pick < 55) begin
			add_text(keyword_names[4'($urandom_range(0, scs_pkg::NUM_KW-1))]);
			if ($urandom_range(0, 4) == 0)
				add_byte(word_char(1'b0));
		end else if (pick < 67) begin
			add_byte(scs_pkg::OP_CHARS[2'($urandom_range(0, scs_pkg::NUM_OP-1))]);
			if ($urandom_range(0, 1))
				add_byte(scs_pkg::CH_EQ);
		end else if (pick < 79) begin
			add_byte(scs_pkg::SYM_CHARS[3'($urandom_range(0, scs_pkg::NUM_SYM-1))]);
		end else if (pick < 92) begin
			add_blank();
		end else begin
			add_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_sources(int n_bytes);
		int target;
		int n;
		target = bytes_queued + n_bytes;
		while (bytes_queued < target) begin
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++) begin
				add_lexeme();
				if ($urandom_range(0, 1))
					add_blank();
			end
			close_source();
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || s_axis_tvalid || expected_tokens.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// long word, dot after word, NUL, 0xFF, newline, float ending in dot at final
		add_text("interfaces.");
		add_byte(8'h00);
		add_byte(8'hff);
		add_text("\n7.");
		close_source();
		// final byte is a blank: no token carries source_done
		add_text("if \r");
		close_source();
		// final byte yields two tokens
		add_text("<(");
		close_source();
		wait_drained();

		send_idle_max = 15;
		recv_idle_max = 15;
		add_sources(110);
		wait_drained();

		// receiver holds off while the sender keeps offering
		send_idle_max = 0;
		recv_idle_max = 2;
		add_sources(110);
		repeat (10) @(negedge clk);
		long_hold_len = LONG_HOLD;
		wait_drained();

		send_idle_max = 5;
		recv_idle_max = 15;
		add_sources(110);
		wait_drained();

		send_idle_max = 15;
		recv_idle_max = 0;
		add_sources(110);
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
